@@ design/mse_pkg.sv @@
// shared types and constants for the mips subset execute unit
`default_nettype none
package mse_pkg;
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_MFHI = 6'd16;
  localparam logic [5:0] FN_MFLO = 6'd18;
  localparam logic [5:0] FN_MULT = 6'd24;
  localparam logic [5:0] FN_DIV  = 6'd26;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_SLT  = 6'd42;

  localparam logic [4:0] RA_REG = 5'd31;
  localparam int unsigned MD_STEPS = 32;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture instruction, read rs and rt
    logic exec;      // evaluate, start mul/div or memory access
    logic md_step;   // one mul/div iteration
    logic commit;    // write back and build the result
  } mse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_md;
    logic is_lw;
  } mse_sts_t;
endpackage
`default_nettype wire

@@ design/mse_ram.sv @@
// generic single port ram with registered read
`default_nettype none
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // single port, registered read returns the word held before a write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ design/mse_ctrl.sv @@
// controller state machine of the execute unit
`default_nettype none
module mse_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mse_pkg::mse_sts_t sts_i,
  output mse_pkg::mse_cmd_t      cmd_o
);
  import mse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MD   = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       ov_q, ov_d;
  logic       free;

  // output register frees when it is taken
  assign free        = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign in_ready_o  = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        cnt_d      = '0;
        if (sts_i.is_md) state_d = S_MD;
        else if (sts_i.is_lw) state_d = S_MEM;
        else state_d = S_DONE;
      end
      S_MD: begin
        cmd_o.md_step = 1'b1;
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == 6'(MD_STEPS - 1)) state_d = S_DONE;
      end
      S_MEM: state_d = S_DONE;
      S_DONE: begin
        if (free) begin
          cmd_o.commit = 1'b1;
          ov_d         = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!ov_q || out_ready_i)) else $error("commit over held result");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("several commands at once");
  a_md_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MD) |-> (cnt_q < 6'(MD_STEPS))) else $error("md count overrun");
endmodule
`default_nettype wire

@@ design/mse_dp.sv @@
// datapath: register file, hi/lo, pc, iterative mul/div, data memory
`default_nettype none
module mse_dp #(
  parameter int unsigned DmemWords = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mse_pkg::mse_cmd_t cmd_i,
  output mse_pkg::mse_sts_t      sts_o,
  input  wire logic [31:0]       instr_i,
  input  wire logic              pc_we_i,
  input  wire logic [31:0]       pc_wdata_i,
  output logic      [31:0]       start_pc_o,
  output logic      [143:0]      res_o
);
  import mse_pkg::*;
  localparam int unsigned AW = $clog2(DmemWords);

  logic [31:0] ir_q, vs_q, vt_q, pc_q, hi_q, lo_q, spc_q;
  logic [31:0] regs_q [32];
  logic [31:0] res_npc_q, res_dv_q, res_addr_q, res_sd_q;
  logic [4:0]  res_di_q;
  logic        res_wr_q, res_st_q, res_hl_q, res_bad_q;
  logic [31:0] npc_q, dv_q, addr_q, sd_q;
  logic [4:0]  di_q;
  logic        wr_q, st_q, hl_q, bad_q, lw_q;
  logic [31:0] rdata;

  // decode fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] simm, pc4, btgt, jtgt;
  assign op   = ir_q[31:26];
  assign rs   = ir_q[25:21];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign sa   = ir_q[10:6];
  assign fn   = ir_q[5:0];
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign pc4  = pc_q + 32'd4;
  assign btgt = pc4 + {simm[29:0], 2'b00};
  assign jtgt = {pc4[31:28], ir_q[25:0], 2'b00};

  assign sts_o.is_md = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_DIV);
  assign sts_o.is_lw = (op == OP_LW);

  // execute decoder
  logic [31:0] e_npc, e_dv, e_addr, e_sd;
  logic [4:0]  e_di;
  logic        e_wr, e_st, e_bad;
  always_comb begin
    e_npc = pc4; e_dv = '0; e_addr = '0; e_sd = '0; e_di = '0;
    e_wr = 1'b0; e_st = 1'b0; e_bad = 1'b0;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL:  begin e_wr = 1'b1; e_di = rd; e_dv = vt_q << sa; end
          FN_SRL:  begin e_wr = 1'b1; e_di = rd; e_dv = vt_q >> sa; end
          FN_JR:   e_npc = vs_q;
          FN_MFHI: begin e_wr = 1'b1; e_di = rd; e_dv = hi_q; end
          FN_MFLO: begin e_wr = 1'b1; e_di = rd; e_dv = lo_q; end
          FN_MULT, FN_DIV: ;
          FN_ADD:  begin e_wr = 1'b1; e_di = rd; e_dv = vs_q + vt_q; end
          FN_SUB:  begin e_wr = 1'b1; e_di = rd; e_dv = vs_q - vt_q; end
          FN_AND:  begin e_wr = 1'b1; e_di = rd; e_dv = vs_q & vt_q; end
          FN_OR:   begin e_wr = 1'b1; e_di = rd; e_dv = vs_q | vt_q; end
          FN_XOR:  begin e_wr = 1'b1; e_di = rd; e_dv = vs_q ^ vt_q; end
          FN_SLT:  begin
            e_wr = 1'b1; e_di = rd;
            e_dv = {31'd0, $signed(vs_q) < $signed(vt_q)};
          end
          default: e_bad = 1'b1;
        endcase
      end
      OP_J:    e_npc = jtgt;
      OP_JAL:  begin e_wr = 1'b1; e_di = RA_REG; e_dv = pc4; e_npc = jtgt; end
      OP_BEQ:  if (vs_q == vt_q) e_npc = btgt;
      OP_BNE:  if (vs_q != vt_q) e_npc = btgt;
      OP_BLEZ: if ($signed(vs_q) <= 0) e_npc = btgt;
      OP_BGTZ: if ($signed(vs_q) > 0) e_npc = btgt;
      OP_ADDI: begin e_wr = 1'b1; e_di = rt; e_dv = vs_q + simm; end
      OP_LUI:  begin e_wr = 1'b1; e_di = rt; e_dv = {ir_q[15:0], 16'd0}; end
      OP_LW:   begin e_wr = 1'b1; e_di = rt; e_addr = vs_q + simm; end
      OP_SW:   begin e_st = 1'b1; e_addr = vs_q + simm; e_sd = vt_q; end
      default: e_bad = 1'b1;
    endcase
  end

  // iterative mul/div on magnitudes: shift-add multiply, restoring divide
  logic [31:0] mb_q, acc_hi_q, acc_lo_q;
  logic        mul_q, na_q, nb_q, dz_q;
  logic [32:0] madd, dsub;
  logic [31:0] drem;
  logic [31:0] mag_s, mag_t;
  assign mag_s = vs_q[31] ? (32'd0 - vs_q) : vs_q;
  assign mag_t = vt_q[31] ? (32'd0 - vt_q) : vt_q;
  assign madd  = {1'b0, acc_hi_q} + {1'b0, (acc_lo_q[0] ? mb_q : 32'd0)};
  assign drem  = {acc_hi_q[30:0], acc_lo_q[31]};
  assign dsub  = {acc_hi_q, acc_lo_q[31]} - {1'b0, mb_q};

  logic [63:0] prod, prod_s;
  logic [31:0] q_s, r_s;
  assign prod   = {acc_hi_q, acc_lo_q};
  assign prod_s = (na_q ^ nb_q) ? (64'd0 - prod) : prod;
  assign q_s    = (na_q ^ nb_q) ? (32'd0 - acc_lo_q) : acc_lo_q;
  assign r_s    = na_q ? (32'd0 - acc_hi_q) : acc_hi_q;

  // data memory
  logic          dm_we;
  logic [AW-1:0] dm_addr;
  assign dm_we   = cmd_i.commit && st_q;
  assign dm_addr = addr_q[AW+1:2];
  mse_ram #(.Width(32), .Depth(DmemWords)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .addr_i  (dm_addr),
    .wdata_i (sd_q),
    .rdata_o (rdata)
  );

  // write back value: loaded word for lw, else the computed value
  logic [31:0] ld_val;
  assign ld_val = lw_q ? rdata : dv_q;

  // control registers: pc, hi, lo, register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      spc_q <= '0;
      hi_q  <= '0;
      lo_q  <= '0;
      for (int i = 0; i < 32; i++) regs_q[i] <= '0;
    end else begin
      if (pc_we_i) begin
        pc_q  <= pc_wdata_i;
        spc_q <= pc_wdata_i;
      end else if (cmd_i.commit) begin
        pc_q <= npc_q;
      end
      if (cmd_i.commit && hl_q) begin
        if (mul_q) begin
          hi_q <= prod_s[63:32];
          lo_q <= prod_s[31:0];
        end else if (dz_q) begin
          hi_q <= vs_q;
          lo_q <= '1;
        end else begin
          hi_q <= r_s;
          lo_q <= q_s;
        end
      end
      if (cmd_i.commit && wr_q && di_q != 5'd0) regs_q[di_q] <= ld_val;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ir_q <= instr_i;
      vs_q <= regs_q[instr_i[25:21]];
      vt_q <= regs_q[instr_i[20:16]];
    end
    if (cmd_i.exec) begin
      npc_q <= e_npc; dv_q <= e_dv; addr_q <= e_addr; sd_q <= e_sd; di_q <= e_di;
      wr_q <= e_wr; st_q <= e_st; bad_q <= e_bad; lw_q <= (op == OP_LW);
      hl_q  <= sts_o.is_md;
      mul_q <= (fn == FN_MULT);
      na_q  <= vs_q[31];
      nb_q  <= vt_q[31];
      dz_q  <= (vt_q == 32'd0);
      mb_q  <= mag_t;
      acc_hi_q <= '0;
      acc_lo_q <= mag_s;
    end
    if (cmd_i.md_step) begin
      if (mul_q) begin
        acc_hi_q <= madd[32:1];
        acc_lo_q <= {madd[0], acc_lo_q[31:1]};
      end else if (!dsub[32]) begin
        acc_hi_q <= dsub[31:0];
        acc_lo_q <= {acc_lo_q[30:0], 1'b1};
      end else begin
        acc_hi_q <= drem;
        acc_lo_q <= {acc_lo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.commit) begin
      res_npc_q  <= npc_q;
      res_wr_q   <= wr_q && di_q != 5'd0;
      res_di_q   <= (wr_q && di_q != 5'd0) ? di_q : 5'd0;
      res_dv_q   <= (wr_q && di_q != 5'd0) ? ld_val : 32'd0;
      res_st_q   <= st_q;
      res_addr_q <= addr_q;
      res_sd_q   <= sd_q;
      res_hl_q   <= hl_q;
      res_bad_q  <= bad_q;
    end
  end

  assign start_pc_o = spc_q;
  // result: npc, wr, di, dv, st, addr, sd, hl, status from low bits up
  assign res_o = {7'd0, res_bad_q, res_hl_q, res_sd_q, res_addr_q, res_st_q,
                  res_dv_q, res_di_q, res_wr_q, res_npc_q};

  a_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q[0] == 32'd0) else $error("r0 written");
  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.commit && !pc_we_i) |=> $stable(pc_q)) else $error("pc moved");
  a_mb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.md_step |=> $stable(mb_q)) else $error("operand moved");
endmodule
`default_nettype wire

@@ design/mips_subset_execute_unit.sv @@
// top level of the mips subset execute unit
// one instruction word enters on the s_axis channel per transfer and one
// result leaves on the m_axis channel. the result passes capture, execute
// and commit, with a data memory read step for lw and, for mult and div,
// the 32-step shared shift-add multiply and restoring divide unit before commit.
// the next instruction is taken in the cycle after the previous one commits,
// so the unit takes no new instruction until the last one has committed,
// while its result may still wait in the output register.
// a stalled receiver holds the result and, after one more instruction has
// executed, holds back its commit and thus s_axis.
// reset clears registers, hi, lo and start_pc and loads the pc with 0; data
// memory is undefined until stored. writing start_pc over apb also presets
// the pc; writes belong only to times when the unit is idle.
`default_nettype none
module mips_subset_execute_unit #(
  parameter int unsigned DMEM_WORDS = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // instr_word
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_pc, reg_write, dest_index, dest_value, store_valid, mem_address,
  // store_data, hilo_write, status, zero fill
  output logic      [143:0] m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import mse_pkg::*;

  localparam logic [1:0] ADDR_START_PC = 2'd0;

  mse_cmd_t cmd;
  mse_sts_t sts;
  logic     pc_we;
  logic [31:0] spc;

  assign pready = 1'b1;
  assign pc_we  = psel && penable && pwrite && (paddr == ADDR_START_PC);
  assign prdata = (paddr == ADDR_START_PC) ? spc : 32'd0;

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mse_dp #(.DmemWords(DMEM_WORDS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .instr_i    (s_axis_tdata),
    .pc_we_i    (pc_we),
    .pc_wdata_i (pwdata),
    .start_pc_o (spc),
    .res_o      (m_axis_tdata)
  );
endmodule
`default_nettype wire
